// File: hw/rtl/pfi_pkg.sv
// Shared types, codes and the divider step of the palette fade interpolator.
package pfi_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int CFG_IDX_W           = 3;
  localparam int CHAN_W              = 8;
  localparam int QUO_W               = 8;
  localparam int REM_W               = 16;
  localparam int DIV_PER_STAGE       = 2;
  localparam int DIV_STAGES          = QUO_W / DIV_PER_STAGE;

  localparam logic [7:0] RST_WINDOW_START = 8'd0;
  localparam logic [7:0] RST_WINDOW_END   = 8'd255;
  localparam logic [7:0] RST_STEP_COUNT   = 8'd30;

  typedef enum logic [1:0] {
    REQ_LOAD_ORIG = 2'd0,
    REQ_LOAD_TGT  = 2'd1,
    REQ_QUERY     = 2'd2
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE_MODE    = 3'd0,
    CFG_WINDOW_START = 3'd1,
    CFG_WINDOW_END   = 3'd2,
    CFG_STEP_COUNT   = 3'd3,
    CFG_SOLID_RED    = 3'd4,
    CFG_SOLID_GREEN  = 3'd5,
    CFG_SOLID_BLUE   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] orig;
    logic              neg;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } lane_t;

  typedef struct packed {
    logic [7:0]             idx;
    logic [7:0]             step;
    logic                   interp;
    logic [2:0][CHAN_W-1:0] bypass;
    lane_t [2:0]            lane;
  } item_t;

  // One restoring division step: try divisor shifted to bit position.
  function automatic lane_t div_step(lane_t l, logic [7:0] d, logic [2:0] bitpos);
    lane_t            r;
    logic [REM_W-1:0] trial;
    r     = l;
    trial = {8'd0, d} << bitpos;
    if (l.rem >= trial) begin
      r.rem         = l.rem - trial;
      r.quo[bitpos] = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/pfi_ifs.sv
// Stream and configuration channel interfaces of the palette fade interpolator.
interface pfi_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] entry_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] fade_step;
  modport source (output valid, req_type, entry_index, red_in, green_in, blue_in, fade_step,
                  input ready);
  modport sink (input valid, req_type, entry_index, red_in, green_in, blue_in, fade_step,
                output ready);
endinterface

interface pfi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] entry_out;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  modport source (output valid, entry_out, red_out, green_out, blue_out, input ready);
  modport sink (input valid, entry_out, red_out, green_out, blue_out, output ready);
endinterface

interface pfi_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pfi_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/pfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = pfi_pkg::PALETTE_ENTRIES_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/palette_fade_interpolator_core.sv
// Top level of the palette fade interpolator: palette stores and fade pipeline.
// Query path: stages 1 to 3, the divider stages, then the output register to out_ch.
// Throughput: one word per cycle unless out_ch stalls; every stage has its own valid bit
// and stalls only when the stage after it is full, so loads and queries stream freely.
// Loads write a palette RAM at acceptance and give no result; the divider is four
// stages of two restoring steps each. Synchronous active-low reset clears valid bits
// and config registers (window 0..255, 30 steps); palette RAM contents stay undefined.
module palette_fade_interpolator_core #(
  parameter int PALETTE_ENTRIES = pfi_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pfi_in_if.sink    in_ch,
  pfi_out_if.source out_ch,
  pfi_cfg_if.sink   cfg_ch
);

  localparam int AW     = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int NDIV   = pfi_pkg::DIV_STAGES;
  localparam int PER    = pfi_pkg::DIV_PER_STAGE;
  localparam int QW     = pfi_pkg::QUO_W;
  localparam int CW     = pfi_pkg::CHAN_W;

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // ---------------------------------------------------------------------------
  logic       fade_mode_r;
  logic [7:0] window_start_r;
  logic [7:0] window_end_r;
  logic [7:0] step_count_r;
  logic [7:0] solid_red_r;
  logic [7:0] solid_green_r;
  logic [7:0] solid_blue_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_mode_r    <= 1'b0;
      window_start_r <= pfi_pkg::RST_WINDOW_START;
      window_end_r   <= pfi_pkg::RST_WINDOW_END;
      step_count_r   <= pfi_pkg::RST_STEP_COUNT;
      solid_red_r    <= 8'd0;
      solid_green_r  <= 8'd0;
      solid_blue_r   <= 8'd0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pfi_pkg::CFG_FADE_MODE:    fade_mode_r    <= cfg_ch.data[0];
        pfi_pkg::CFG_WINDOW_START: window_start_r <= cfg_ch.data;
        pfi_pkg::CFG_WINDOW_END:   window_end_r   <= cfg_ch.data;
        pfi_pkg::CFG_STEP_COUNT:   step_count_r   <= cfg_ch.data;
        pfi_pkg::CFG_SOLID_RED:    solid_red_r    <= cfg_ch.data;
        pfi_pkg::CFG_SOLID_GREEN:  solid_green_r  <= cfg_ch.data;
        pfi_pkg::CFG_SOLID_BLUE:   solid_blue_r   <= cfg_ch.data;
        default: ;  // indexes beyond the register list write nothing
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stall chain: a stage moves when it is empty or the next one moves.
  // ---------------------------------------------------------------------------
  logic            s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic [NDIV-1:0] dv_r;
  logic            s1_adv, s2_adv, s3_adv, out_adv;
  logic [NDIV-1:0] d_adv;
  logic            in_acc;

  always_comb begin
    out_adv        = !out_v_r || out_ch.ready;
    d_adv[NDIV-1]  = !dv_r[NDIV-1] || out_adv;
    for (int k = NDIV - 2; k >= 0; k--) begin
      d_adv[k] = !dv_r[k] || d_adv[k+1];
    end
    s3_adv = !s3_v_r || d_adv[0];
    s2_adv = !s2_v_r || s3_adv;
    s1_adv = !s1_v_r || s2_adv;
  end

  assign in_ch.ready = s1_adv;
  assign in_acc      = in_ch.valid && s1_adv;

  // ---------------------------------------------------------------------------
  // Palette stores. Loads write at acceptance; every accepted word reads both
  // stores at its index, and the read data lines up with stage 1.
  // ---------------------------------------------------------------------------
  logic          in_range;
  logic          is_query;
  logic [AW-1:0] ram_addr;
  logic [23:0]   ram_wdata;
  logic [23:0]   orig_rdata;
  logic [23:0]   tgt_rdata;

  assign in_range  = ({1'b0, in_ch.entry_index} < 9'(PALETTE_ENTRIES));
  assign is_query  = (in_ch.req_type == pfi_pkg::REQ_QUERY);
  assign ram_addr  = in_ch.entry_index[AW-1:0];
  // red sits in the low byte so channel c is bits c*8 +: 8
  assign ram_wdata = {in_ch.blue_in, in_ch.green_in, in_ch.red_in};

  pfi_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_orig_ram (
    .clk   (clk),
    .we    (in_acc && in_range && (in_ch.req_type == pfi_pkg::REQ_LOAD_ORIG)),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (ram_addr),
    .rdata (orig_rdata)
  );

  pfi_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_tgt_ram (
    .clk   (clk),
    .we    (in_acc && in_range && (in_ch.req_type == pfi_pkg::REQ_LOAD_TGT)),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (ram_addr),
    .rdata (tgt_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: query index, step and range flag, beside the RAM read data.
  // Loads and unused codes enter as bubbles.
  // ---------------------------------------------------------------------------
  logic [7:0] s1_idx_r;
  logic [7:0] s1_step_r;
  logic       s1_in_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_ch.valid && is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r      <= in_ch.entry_index;
      s1_step_r     <= in_ch.fade_step;
      s1_in_range_r <= in_range;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: pick the target, saturate the step, and split each channel's
  // difference into sign and magnitude. Cases that need no division settle
  // their answer here and ride along as the bypass value.
  // ---------------------------------------------------------------------------
  pfi_pkg::item_t s2_nxt, s2_r;

  always_comb begin
    logic [CW-1:0] orig_c;
    logic [CW-1:0] tgt_c;
    logic [CW:0]   diff;
    logic [23:0]   solid;
    logic          in_win;
    logic          cnt_zero;
    solid    = {solid_blue_r, solid_green_r, solid_red_r};
    in_win   = (s1_idx_r >= window_start_r) && (s1_idx_r <= window_end_r);
    cnt_zero = (step_count_r == 8'd0);
    s2_nxt        = '0;
    s2_nxt.idx    = s1_idx_r;
    s2_nxt.step   = (s1_step_r > step_count_r) ? step_count_r : s1_step_r;
    s2_nxt.interp = s1_in_range_r && in_win && !cnt_zero;
    for (int c = 0; c < 3; c++) begin
      orig_c = orig_rdata[c*CW +: CW];
      tgt_c  = fade_mode_r ? tgt_rdata[c*CW +: CW] : solid[c*CW +: CW];
      diff   = {1'b0, tgt_c} - {1'b0, orig_c};
      s2_nxt.lane[c].orig = orig_c;
      s2_nxt.lane[c].neg  = diff[CW];
      s2_nxt.lane[c].rem  = {8'd0, diff[CW] ? CW'(-diff) : diff[CW-1:0]};
      s2_nxt.lane[c].quo  = '0;
      if (!s1_in_range_r) begin
        s2_nxt.bypass[c] = '0;
      end else if (!in_win) begin
        s2_nxt.bypass[c] = orig_c;
      end else begin
        // fade already complete when the step count is zero
        s2_nxt.bypass[c] = tgt_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: magnitude times step, one 8x8 multiplier per channel.
  // ---------------------------------------------------------------------------
  pfi_pkg::item_t s3_nxt, s3_r;

  always_comb begin
    s3_nxt = s2_r;
    for (int c = 0; c < 3; c++) begin
      s3_nxt.lane[c].rem = s2_r.lane[c].rem[7:0] * s2_r.step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_r <= s3_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: restoring division of the product by step_count, two
  // quotient bits a stage, MSB first. The saturated step keeps the quotient
  // below 256, so eight bits cover it.
  // ---------------------------------------------------------------------------
  pfi_pkg::item_t dq_nxt [NDIV];
  pfi_pkg::item_t dq_r   [NDIV];

  always_comb begin
    pfi_pkg::item_t cur;
    for (int k = 0; k < NDIV; k++) begin
      cur = (k == 0) ? s3_r : dq_r[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < PER; j++) begin
        for (int c = 0; c < 3; c++) begin
          cur.lane[c] = pfi_pkg::div_step(cur.lane[c], step_count_r,
                                          3'(QW - 1 - k * PER - j));
        end
      end
      dq_nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else begin
      for (int k = 0; k < NDIV; k++) begin
        if (d_adv[k]) begin
          dv_r[k] <= (k == 0) ? s3_v_r : dv_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIV; k++) begin
      if (d_adv[k]) begin
        dq_r[k] <= dq_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: pick the bypass value, or apply the sign (truncation
  // toward zero: the magnitude is divided), add the original and wrap to 8 bits.
  // ---------------------------------------------------------------------------
  pfi_pkg::item_t     fin;
  logic [2:0][CW-1:0] res_nxt;
  logic [2:0][CW-1:0] res_r;
  logic [7:0]         out_idx_r;

  always_comb begin
    logic [CW-1:0] delta;
    fin = dq_r[NDIV-1];
    for (int c = 0; c < 3; c++) begin
      delta      = fin.lane[c].neg ? CW'(-fin.lane[c].quo) : fin.lane[c].quo;
      res_nxt[c] = fin.interp ? CW'(fin.lane[c].orig + delta) : fin.bypass[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= dv_r[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      res_r     <= res_nxt;
      out_idx_r <= fin.idx;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.entry_out = out_idx_r;
  assign out_ch.red_out   = res_r[0];
  assign out_ch.green_out = res_r[1];
  assign out_ch.blue_out  = res_r[2];

endmodule

// File: hw/rtl/pfi_checker.sv
// Port-level checker of the palette fade interpolator and its bind.
module pfi_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] entry_out,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out
);

  // a result waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(entry_out) && $stable(red_out) &&
                                $stable(green_out) && $stable(blue_out))
    else $error("stalled result word changed");

  // an empty output register means no stage can be blocked
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // reset flushes the pipeline
  a_flush_on_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind palette_fade_interpolator_core pfi_checker u_pfi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .entry_out (out_ch.entry_out),
  .red_out   (out_ch.red_out),
  .green_out (out_ch.green_out),
  .blue_out  (out_ch.blue_out)
);
